/* hdl/nfc_response_frame_parser_macros.svh */
// Assertion macros shared by the frame parser RTL.
`ifndef NFC_RESPONSE_FRAME_PARSER_MACROS_SVH
`define NFC_RESPONSE_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define NRFP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define NRFP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/nfcrfp_pkg.sv */
// Types and constants of the response frame parser.
package nfcrfp_pkg;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_READY = 3'd1,
        ST_TIMEOUT   = 3'd2,
        ST_INVALID   = 3'd3,
        ST_NO_SPACE  = 3'd4
    } t_status;

    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_EXP_CMD    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESP_TFI   = 8'd3;

    localparam logic [7:0] PREAMBLE_BYTE = 8'h00;
    localparam logic [7:0] START_BYTE_1  = 8'h00;
    localparam logic [7:0] START_BYTE_2  = 8'hFF;

    localparam logic [7:0]  RST_EXP_CMD    = 8'd0;
    localparam logic [7:0]  RST_CAPACITY   = 8'd64;
    localparam logic [15:0] RST_POLL_LIMIT = 16'd0;
    localparam logic [7:0]  RST_RESP_TFI   = 8'hD5;

endpackage

/* hdl/nfc_response_frame_parser.sv */
// A result is loaded into the output register at the clock edge of its byte's transfer.
// Throughput: one byte per cycle; a byte is taken while a result waits, as long as
// the output register is free or is emptied in the same cycle.
// Reset (i_rst_n low at a clock edge, synchronous) returns the parser to idle,
// clears counters and the output valid, and loads the register defaults.
`include "nfc_response_frame_parser_macros.svh"

module nfc_response_frame_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [nfcrfp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data,
    // received bytes
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] rx_byte
    input  logic [0:0]                     s_axis_tuser,  // [0] read_start
    // results
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [23:0]                    m_axis_tdata,  // [7:0] data_byte,
                                                          // [10:8] status,
                                                          // [18:11] data_count
    output logic [0:0]                     m_axis_tuser   // [0] is_final
);
    import nfcrfp_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_PRE  = 4'd1,
        PH_SC1  = 4'd2,
        PH_SC2  = 4'd3,
        PH_LEN  = 4'd4,
        PH_LCS  = 4'd5,
        PH_TFI  = 4'd6,
        PH_CMD  = 4'd7,
        PH_DATA = 4'd8,
        PH_DCS  = 4'd9
    } t_phase;

    // configuration
    logic [7:0]  r_exp_cmd;
    logic [7:0]  r_capacity;
    logic [15:0] r_poll_limit;
    logic [7:0]  r_resp_tfi;

    // parser state
    t_phase      r_phase,  n_phase;
    logic [7:0]  r_frame_len, n_frame_len;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_delivered, n_delivered;
    logic [15:0] r_poll_cnt, n_poll_cnt;

    // output register
    logic        r_out_valid;
    logic        r_out_final, n_out_final;
    logic [7:0]  r_out_byte, n_out_byte;
    t_status     r_out_status, n_out_status;
    logic [7:0]  r_out_count, n_out_count;
    logic        n_emit;

    logic        in_xfer;
    logic [7:0]  rx_byte;
    logic        read_start;
    logic [15:0] poll_inc;
    logic [7:0]  payload_len;
    logic [7:0]  cmd_reply;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign rx_byte       = s_axis_tdata;
    assign read_start    = s_axis_tuser[0];

    assign poll_inc    = (r_poll_cnt == 16'hFFFF) ? r_poll_cnt : r_poll_cnt + 16'd1;
    assign payload_len = r_frame_len - 8'd2;
    assign cmd_reply   = r_exp_cmd + 8'd1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_final;
    assign m_axis_tdata  = {5'd0, r_out_count, r_out_status, r_out_byte};

    always_comb begin
        n_phase      = r_phase;
        n_frame_len  = r_frame_len;
        n_bytes_left = r_bytes_left;
        n_sum        = r_sum;
        n_delivered  = r_delivered;
        n_poll_cnt   = r_poll_cnt;
        n_emit       = 1'b0;
        n_out_final  = 1'b1;
        n_out_byte   = 8'd0;
        n_out_status = ST_OK;
        n_out_count  = 8'd0;

        if (read_start) begin
            if (!rx_byte[0]) begin
                // reader busy: count the poll, close the read
                n_phase = PH_IDLE;
                n_emit  = 1'b1;
                if (r_poll_limit != 16'd0 && poll_inc > r_poll_limit) begin
                    n_poll_cnt   = 16'd0;
                    n_out_status = ST_TIMEOUT;
                end else begin
                    n_poll_cnt   = poll_inc;
                    n_out_status = ST_NOT_READY;
                end
            end else begin
                n_poll_cnt   = 16'd0;
                n_phase      = PH_PRE;
                n_frame_len  = 8'd0;
                n_bytes_left = 8'd0;
                n_sum        = 8'd0;
                n_delivered  = 8'd0;
            end
        end else begin
            case (r_phase)
                PH_PRE: begin
                    if (rx_byte != PREAMBLE_BYTE) begin
                        n_phase = PH_IDLE; n_emit = 1'b1; n_out_status = ST_INVALID;
                    end else begin
                        n_phase = PH_SC1;
                    end
                end
                PH_SC1: begin
                    if (rx_byte != START_BYTE_1) begin
                        n_phase = PH_IDLE; n_emit = 1'b1; n_out_status = ST_INVALID;
                    end else begin
                        n_phase = PH_SC2;
                    end
                end
                PH_SC2: begin
                    if (rx_byte != START_BYTE_2) begin
                        n_phase = PH_IDLE; n_emit = 1'b1; n_out_status = ST_INVALID;
                    end else begin
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_frame_len = rx_byte;
                    n_phase     = PH_LCS;
                end
                PH_LCS: begin
                    if (r_frame_len + rx_byte != 8'd0) begin
                        n_phase = PH_IDLE; n_emit = 1'b1; n_out_status = ST_INVALID;
                    end else begin
                        n_phase = PH_TFI;
                    end
                end
                PH_TFI: begin
                    if (rx_byte != r_resp_tfi) begin
                        n_phase = PH_IDLE; n_emit = 1'b1; n_out_status = ST_INVALID;
                    end else begin
                        n_sum   = rx_byte;
                        n_phase = PH_CMD;
                    end
                end
                PH_CMD: begin
                    if (rx_byte != cmd_reply) begin
                        n_phase = PH_IDLE; n_emit = 1'b1; n_out_status = ST_INVALID;
                    end else if (r_frame_len < 8'd2 || payload_len > r_capacity) begin
                        n_phase = PH_IDLE; n_emit = 1'b1; n_out_status = ST_NO_SPACE;
                    end else begin
                        n_sum        = r_sum + rx_byte;
                        n_bytes_left = payload_len;
                        n_delivered  = 8'd0;
                        n_phase      = (payload_len == 8'd0) ? PH_DCS : PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_sum        = r_sum + rx_byte;
                    n_delivered  = r_delivered + 8'd1;
                    n_bytes_left = r_bytes_left - 8'd1;
                    if (r_bytes_left == 8'd1) begin
                        n_phase = PH_DCS;
                    end
                    n_emit      = 1'b1;
                    n_out_final = 1'b0;
                    n_out_byte  = rx_byte;
                    n_out_count = r_delivered + 8'd1;
                end
                PH_DCS: begin
                    n_phase = PH_IDLE;
                    n_emit  = 1'b1;
                    if (r_sum + rx_byte != 8'd0) begin
                        n_out_status = ST_INVALID;
                    end else begin
                        n_out_count = r_delivered;
                    end
                end
                default: begin
                    // stray byte outside a read: drop
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_cmd    <= RST_EXP_CMD;
            r_capacity   <= RST_CAPACITY;
            r_poll_limit <= RST_POLL_LIMIT;
            r_resp_tfi   <= RST_RESP_TFI;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_EXP_CMD:    r_exp_cmd    <= i_cfg_data[7:0];
                CFG_CAPACITY:   r_capacity   <= i_cfg_data[7:0];
                CFG_POLL_LIMIT: r_poll_limit <= i_cfg_data;
                CFG_RESP_TFI:   r_resp_tfi   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_frame_len  <= 8'd0;
            r_bytes_left <= 8'd0;
            r_sum        <= 8'd0;
            r_delivered  <= 8'd0;
            r_poll_cnt   <= 16'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_phase      <= n_phase;
                r_frame_len  <= n_frame_len;
                r_bytes_left <= n_bytes_left;
                r_sum        <= n_sum;
                r_delivered  <= n_delivered;
                r_poll_cnt   <= n_poll_cnt;
            end
            if (in_xfer && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload of the output register: load on a transfer that yields a result
    always_ff @(posedge i_clk) begin
        if (in_xfer && n_emit) begin
            r_out_final  <= n_out_final;
            r_out_byte   <= n_out_byte;
            r_out_status <= n_out_status;
            r_out_count  <= n_out_count;
        end
    end

    `NRFP_ASSERT_IMP(a_data_ok, r_out_valid && !r_out_final, r_out_status == ST_OK, "data result with non-ok status")
    `NRFP_ASSERT_IMP(a_fail_cnt, r_out_valid && r_out_status != ST_OK, r_out_count == 8'd0, "failed result carries a count")
    `NRFP_ASSERT_IMP(a_dcs_empty, r_phase == PH_DCS, r_bytes_left == 8'd0, "checksum phase with bytes left")
    `NRFP_ASSERT_NXT(a_ready_open, in_xfer && read_start && rx_byte[0], r_phase == PH_PRE, "ready status did not open a frame")

endmodule

/* dv/nfc_response_frame_parser_tb.sv */
// Self-checking testbench for the response frame parser: directed table, then random reads.
module nfc_response_frame_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nfcrfp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 80;
    localparam int PHASE_BYTES  = 55;

    typedef enum logic [3:0] {
        P_IDLE, P_PRE, P_SC1, P_SC2, P_LEN, P_LCS, P_TFI, P_CMD, P_DATA, P_DCS
    } t_parse_phase;

    typedef struct packed {
        logic       is_final;
        logic [7:0] data_byte;
        t_status    status;
        logic [7:0] data_count;
    } t_frame_result;

    typedef struct packed {
        logic [7:0]    b;
        logic          st;
        logic          fixed;
        t_frame_result res;
    } t_stim_row;

    localparam t_frame_result NO_RES = '0;

    // Rows with a typed result are checked against it; the rest against the predictor.
    localparam t_stim_row DIRECTED [25] = '{
        '{8'h00, 1'b1, 1'b1, '{1'b1, 8'h00, ST_NOT_READY, 8'd0}}, // busy straight after reset
        '{8'hFF, 1'b0, 1'b0, NO_RES},                             // stray byte while idle
        '{8'h01, 1'b1, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b1, 1'b0, NO_RES},                             // new read drops the old one
        '{PREAMBLE_BYTE, 1'b0, 1'b0, NO_RES},
        '{START_BYTE_1, 1'b0, 1'b0, NO_RES},
        '{START_BYTE_2, 1'b0, 1'b0, NO_RES},
        '{8'h03, 1'b0, 1'b0, NO_RES},
        '{8'hFD, 1'b0, 1'b0, NO_RES},
        '{8'hD5, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'h2B, 1'b0, 1'b1, '{1'b1, 8'h00, ST_OK, 8'd1}},
        '{8'hFE, 1'b1, 1'b1, '{1'b1, 8'h00, ST_NOT_READY, 8'd0}},
        '{8'h01, 1'b1, 1'b0, NO_RES},
        '{PREAMBLE_BYTE, 1'b0, 1'b0, NO_RES},
        '{START_BYTE_1, 1'b0, 1'b0, NO_RES},
        '{START_BYTE_2, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b0, NO_RES},                             // length below two
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hD5, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b1, '{1'b1, 8'h00, ST_NO_SPACE, 8'd0}},
        '{8'h01, 1'b1, 1'b0, NO_RES},
        '{8'h7F, 1'b0, 1'b1, '{1'b1, 8'h00, ST_INVALID, 8'd0}}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;
    logic [0:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [23:0]          m_axis_tdata;
    logic [0:0]           m_axis_tuser;

    nfc_response_frame_parser DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // predictor state and register copies
    logic [7:0]   cfg_exp_cmd    = RST_EXP_CMD;
    logic [7:0]   cfg_capacity   = RST_CAPACITY;
    logic [15:0]  cfg_poll_limit = RST_POLL_LIMIT;
    logic [7:0]   cfg_tfi        = RST_RESP_TFI;
    t_parse_phase parse_phase    = P_IDLE;
    logic [7:0]   hdr_len        = '0;
    logic [7:0]   payload_left   = '0;
    logic [7:0]   frame_sum      = '0;
    logic [7:0]   delivered      = '0;
    logic [15:0]  poll_cnt       = '0;

    t_frame_result expected_results[$];
    t_frame_result seen_exp;
    int            fail_cnt      = 0;
    int            cycle_cnt     = 0;
    int            bytes_used    = 0;
    bit            offer_open    = 1'b0;
    bit            quiet_tail    = 1'b0;
    bit            long_hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit parse_byte(input logic [7:0] b, input logic rd_start,
                                      output t_frame_result r);
        bit bad;
        bad = 1'b0;
        r   = '{1'b1, 8'h00, ST_OK, 8'h00};
        if (rd_start) begin
            if (!b[0]) begin
                if (poll_cnt != 16'hFFFF) poll_cnt++;
                parse_phase = P_IDLE;
                if (cfg_poll_limit != 0 && poll_cnt > cfg_poll_limit) begin
                    poll_cnt = '0;
                    r.status = ST_TIMEOUT;
                end else begin
                    r.status = ST_NOT_READY;
                end
                return 1'b1;
            end
            poll_cnt     = '0;
            parse_phase  = P_PRE;
            hdr_len      = '0;
            payload_left = '0;
            frame_sum    = '0;
            delivered    = '0;
            return 1'b0;
        end
        case (parse_phase)
            P_PRE: begin
                bad = (b != PREAMBLE_BYTE);
                parse_phase = P_SC1;
            end
            P_SC1: begin
                bad = (b != START_BYTE_1);
                parse_phase = P_SC2;
            end
            P_SC2: begin
                bad = (b != START_BYTE_2);
                parse_phase = P_LEN;
            end
            P_LEN: begin
                hdr_len = b;
                parse_phase = P_LCS;
            end
            P_LCS: begin
                bad = (8'(hdr_len + b) != 8'h00);
                parse_phase = P_TFI;
            end
            P_TFI: begin
                bad = (b != cfg_tfi);
                frame_sum = b;
                parse_phase = P_CMD;
            end
            P_CMD: begin
                if (b != 8'(cfg_exp_cmd + 1)) begin
                    bad = 1'b1;
                end else if (hdr_len < 2 || 8'(hdr_len - 2) > cfg_capacity) begin
                    parse_phase = P_IDLE;
                    r.status = ST_NO_SPACE;
                    return 1'b1;
                end else begin
                    frame_sum    = frame_sum + b;
                    payload_left = 8'(hdr_len - 2);
                    delivered    = '0;
                    parse_phase  = (payload_left == 0) ? P_DCS : P_DATA;
                end
            end
            P_DATA: begin
                frame_sum    = frame_sum + b;
                delivered    = 8'(delivered + 1);
                payload_left = 8'(payload_left - 1);
                if (payload_left == 0) parse_phase = P_DCS;
                r = '{1'b0, b, ST_OK, delivered};
                return 1'b1;
            end
            P_DCS: begin
                parse_phase = P_IDLE;
                if (8'(frame_sum + b) != 8'h00) begin
                    bad = 1'b1;
                end else begin
                    r.data_count = delivered;
                    return 1'b1;
                end
            end
            default: begin
                parse_phase = P_IDLE;
                return 1'b0;
            end
        endcase
        if (bad) begin
            parse_phase = P_IDLE;
            r.status = ST_INVALID;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic hold_sender();
        if (offer_open) begin
            s_axis_tvalid <= 1'b0;
            offer_open = 1'b0;
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic rd_start,
                             input bit fixed = 1'b0, input t_frame_result fixed_res = '0);
        t_frame_result res;
        bit            got;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= rd_start;
        do @(posedge i_clk); while (!s_axis_tready);
        if (rd_start || parse_phase != P_IDLE) bytes_used++;
        got = parse_byte(b, rd_start, res);
        if (fixed) expected_results.push_back(fixed_res);
        else if (got) expected_results.push_back(res);
        offer_open = 1'b1;
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            hold_sender();
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // Leave i_cfg_valid high; the caller lowers it after the last transfer.
    task automatic cfg_send(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_EXP_CMD:    cfg_exp_cmd    = val[7:0];
            CFG_CAPACITY:   cfg_capacity   = val[7:0];
            CFG_POLL_LIMIT: cfg_poll_limit = val;
            CFG_RESP_TFI:   cfg_tfi        = val[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int p);
        logic [7:0]  cmd;
        logic [7:0]  cap;
        logic [7:0]  tfi;
        logic [15:0] lim;
        cmd = 8'($urandom);
        cap = 8'($urandom_range(0, 16));
        lim = 16'($urandom_range(2, 6));
        tfi = 8'($urandom);
        case (p)
            0: begin
                cmd = RST_EXP_CMD;
                cap = RST_CAPACITY;
                lim = RST_POLL_LIMIT;
                tfi = RST_RESP_TFI;
            end
            1: begin
                cmd = 8'hFF;
                cap = 8'd0;
                lim = 16'd1;
                tfi = 8'h00;
            end
            2: begin
                cap = 8'd253;
                lim = 16'd3;
                tfi = 8'hFF;
            end
            3: lim = 16'hFFFF;
            4: begin
                cap = 8'($urandom_range(4, 32));
                tfi = RST_RESP_TFI;
            end
            default: cap = 8'd40;
        endcase
        // upper byte of the 8-bit registers carries junk that must be dropped
        cfg_send(CFG_EXP_CMD, {8'($urandom), cmd});
        cfg_send(CFG_CAPACITY, {8'($urandom), cap});
        cfg_send(CFG_POLL_LIMIT, lim);
        cfg_send(CFG_RESP_TFI, {8'($urandom), tfi});
        i_cfg_valid <= 1'b0;
    endtask

    // One read: a frame (often damaged or cut short), a run of busy polls, or noise.
    task automatic send_read(input bit force_good, input int force_len);
        logic [7:0]  fb[$];
        logic [7:0]  len_b;
        logic [7:0]  sum_b;
        logic [7:0]  d;
        int unsigned pick;
        int unsigned n;
        int unsigned nsend;
        pick = force_good ? 0 : $urandom_range(0, 99);
        if (pick >= 90) begin
            repeat ($urandom_range(1, 5)) push_byte({7'($urandom), 1'b0}, 1'b1);
            return;
        end
        if (pick >= 85) begin
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom), $urandom_range(0, 3) == 0);
            return;
        end
        if (force_len >= 0) begin
            len_b = 8'(force_len + 2);
        end else begin
            case ($urandom_range(0, 15))
                0: len_b = 8'(cfg_capacity + 2);
                1: len_b = 8'(cfg_capacity + 3);
                2: len_b = 8'($urandom_range(0, 1));
                default: len_b = 8'(2 + $urandom_range(0, (cfg_capacity < 10) ? cfg_capacity : 10));
            endcase
        end
        n = (len_b < 2) ? 0 : len_b - 2;
        if (n > cfg_capacity) n = 2;  // rejected anyway; send a couple of strays
        fb = '{PREAMBLE_BYTE, START_BYTE_1, START_BYTE_2, len_b, 8'(0 - len_b),
               cfg_tfi, 8'(cfg_exp_cmd + 1)};
        sum_b = 8'(cfg_tfi + cfg_exp_cmd + 1);
        repeat (n) begin
            d = 8'($urandom);
            fb.push_back(d);
            sum_b = sum_b + d;
        end
        fb.push_back(8'(0 - sum_b));
        nsend = fb.size();
        if (!force_good) begin
            if ($urandom_range(0, 4) == 0)
                fb[$urandom_range(0, fb.size() - 1)] ^= 8'($urandom_range(1, 255));
            if ($urandom_range(0, 9) == 0)
                nsend = $urandom_range(0, fb.size() - 1);
        end
        push_byte({7'($urandom), 1'b1}, 1'b1);
        for (int i = 0; i < nsend; i++) push_byte(fb[i], 1'b0);
        // postamble, ignored by the parser once the frame has ended
        if ($urandom_range(0, 1) == 0) push_byte(8'h00, 1'b0);
    endtask

    task automatic settle();
        hold_sender();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] e, input logic [7:0] a);
        if (a !== e) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected: tdata 0x%0h tuser %0b",
                       m_axis_tdata, m_axis_tuser);
                fail_cnt++;
            end else begin
                seen_exp = expected_results.pop_front();
                check_field("is_final", 8'(seen_exp.is_final), 8'(m_axis_tuser[0]));
                check_field("data_byte", seen_exp.data_byte, m_axis_tdata[7:0]);
                check_field("status", 8'(seen_exp.status), 8'(m_axis_tdata[10:8]));
                check_field("data_count", seen_exp.data_count, m_axis_tdata[18:11]);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: short random stalls, one long hold-off on request, none in the tail
    initial begin : sink_ctrl
        int unsigned stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && !quiet_tail && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 7);
            end
            if (stall_left != 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int phase_start;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < $size(DIRECTED); i++)
            push_byte(DIRECTED[i].b, DIRECTED[i].st, DIRECTED[i].fixed, DIRECTED[i].res);

        for (int p = 0; p < 6; p++) begin
            settle();
            quiet_tail = (p == 5);
            apply_setting(p);
            phase_start = bytes_used;
            // fill the output side while the receiver holds off
            if (p == 0) begin
                long_hold_req = 1'b1;
                send_read(1'b1, 24);
            end
            if (p == 2) send_read(1'b1, 253);
            while (bytes_used - phase_start < PHASE_BYTES) send_read(1'b0, -1);
        end

        hold_sender();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
